### src/heisenberg_term_generator_unit_assert.svh
// Assertion macros for the Heisenberg term generator.
// Depends on nothing; included by the modules that check their own logic.
`ifndef HEISENBERG_TERM_GENERATOR_UNIT_ASSERT_SVH
`define HEISENBERG_TERM_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define HTG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/htg_pkg.sv
// Package for the Heisenberg term generator: word types, codes, rounding.
// Depends on nothing; used by every module of the block.
package htg_pkg;

  localparam int unsigned SITE_W  = 6;
  localparam int unsigned SLOT_W  = 5;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned COEF_W  = 32;
  localparam int unsigned CPL_W   = 16;
  localparam int unsigned PROD_W  = COEF_W + CPL_W;
  localparam int unsigned SPIN_W  = 64;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_APPLY = 1'b1;

  localparam logic REG_EDGES_IN_USE = 1'b0;

  typedef struct packed {
    logic                     opcode;
    logic [SLOT_W-1:0]        edge_slot;
    logic [SITE_W-1:0]        site_first;
    logic [SITE_W-1:0]        site_second;
    logic signed [CPL_W-1:0]  edge_coupling;
    logic [SPIN_W-1:0]        spin_bits;
    logic signed [COEF_W-1:0] coeff_real;
    logic signed [COEF_W-1:0] coeff_imag;
  } htg_in_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] term_real;
    logic signed [COEF_W-1:0] term_imag;
    logic [SPIN_W-1:0]        term_spins;
    logic                     overflowed;
    logic                     last_term;
  } htg_out_t;

  typedef struct packed {
    logic [SITE_W-1:0]       site_a;
    logic [SITE_W-1:0]       site_b;
    logic signed [CPL_W-1:0] coupling;
  } htg_edge_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } htg_rd_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL_RE,
    ST_MUL_IM,
    ST_EMIT_DIAG,
    ST_EMIT_FLIP
  } htg_state_e;

  typedef enum logic [1:0] {
    SC_POS,
    SC_NEG,
    SC_DBL
  } htg_scale_e;

  // Q24.24 product -> Q16.16, round half up, saturate; bit 32 is the overflow flag
  function automatic logic [COEF_W:0] scale_sat(logic signed [PROD_W-1:0] p,
                                                htg_scale_e mode);
    logic signed [PROD_W+1:0] x;
    logic signed [PROD_W-7:0] r;
    logic                     ovf;
    logic [COEF_W-1:0]        v;
    x = {{2{p[PROD_W-1]}}, p};
    case (mode)
      SC_POS:  x = x;
      SC_NEG:  x = -x;
      SC_DBL:  x = x <<< 1;
      default: x = x;
    endcase
    x = x + (PROD_W+2)'(128);
    r = x[PROD_W+1:8];
    ovf = !((&r[PROD_W-7:COEF_W-1]) || !(|r[PROD_W-7:COEF_W-1]));
    if (ovf) begin
      v = r[PROD_W-7] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end else begin
      v = r[COEF_W-1:0];
    end
    return {ovf, v};
  endfunction

endpackage

### src/htg_edge_mem.sv
// Edge table memory: one write port, one registered read port.
// Depends on htg_pkg for the entry type.
module htg_edge_mem #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [htg_pkg::SLOT_W-1:0] waddr_i,
  input  htg_pkg::htg_edge_t   wdata_i,
  input  htg_pkg::htg_rd_req_t rd_i,
  output htg_pkg::htg_edge_t   rdata_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  htg_pkg::htg_edge_t mem_q [DEPTH];
  htg_pkg::htg_edge_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i[AW-1:0]] <= wdata_i;
    end
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/htg_mult.sv
// Shared signed multiplier, coefficient times coupling, registered product.
// Depends on htg_pkg for widths.
module htg_mult (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [htg_pkg::COEF_W-1:0]   a_i,
  input  logic signed [htg_pkg::CPL_W-1:0]    b_i,
  output logic signed [htg_pkg::PROD_W-1:0]   prod_o
);

  logic signed [htg_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

### src/htg_seq.sv
// Sequencer: walks the edge table, drives the shared multiplier, forms terms
// and holds the output register. Depends on htg_pkg and the assertion header.
`include "heisenberg_term_generator_unit_assert.svh"

module htg_seq #(
  parameter int unsigned SPIN_SITES   = 64,
  parameter int unsigned EDGE_ENTRIES = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [htg_pkg::CNT_W-1:0]         edges_in_use_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  htg_pkg::htg_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output htg_pkg::htg_out_t                 out_data_o,
  output htg_pkg::htg_rd_req_t              rd_o,
  input  htg_pkg::htg_edge_t                rdata_i,
  output logic                              mul_en_o,
  output logic signed [htg_pkg::COEF_W-1:0] mul_a_o,
  input  logic signed [htg_pkg::PROD_W-1:0] prod_i
);

  localparam logic [htg_pkg::CNT_W-1:0] WALK_MAX = htg_pkg::CNT_W'(EDGE_ENTRIES);
  localparam logic [htg_pkg::SITE_W:0]  SITE_LIM = (htg_pkg::SITE_W+1)'(SPIN_SITES);

  htg_pkg::htg_state_e                state_q, state_d;
  logic [htg_pkg::CNT_W-1:0]          idx_q, idx_d;
  logic [htg_pkg::CNT_W-1:0]          walk_q, walk_d;
  logic [htg_pkg::SPIN_W-1:0]         spins_q, spins_d;
  logic signed [htg_pkg::COEF_W-1:0]  cr_q, cr_d, ci_q, ci_d;
  logic signed [htg_pkg::PROD_W-1:0]  pr_q, pr_d;
  logic                               aligned_q, aligned_d;
  logic                               out_valid_q, out_valid_d;
  htg_pkg::htg_out_t                  out_q, out_d;

  logic                               accept;
  logic                               out_free;
  logic                               out_load;
  logic                               last_edge;
  logic                               a_ok, b_ok;
  logic                               spin_a, spin_b;
  logic [htg_pkg::SPIN_W-1:0]         flip_mask;
  logic [htg_pkg::COEF_W:0]           sc_re, sc_im;
  htg_pkg::htg_scale_e                mode;

  assign accept    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign last_edge = (idx_q + htg_pkg::CNT_W'(1)) == walk_q;

  assign a_ok   = {1'b0, rdata_i.site_a} < SITE_LIM;
  assign b_ok   = {1'b0, rdata_i.site_b} < SITE_LIM;
  assign spin_a = a_ok && spins_q[rdata_i.site_a];
  assign spin_b = b_ok && spins_q[rdata_i.site_b];
  assign flip_mask = (a_ok ? (htg_pkg::SPIN_W'(1) << rdata_i.site_a) : '0)
                   ^ (b_ok ? (htg_pkg::SPIN_W'(1) << rdata_i.site_b) : '0);

  always_comb begin
    case (state_q)
      htg_pkg::ST_EMIT_FLIP: mode = htg_pkg::SC_DBL;
      default:               mode = aligned_q ? htg_pkg::SC_POS : htg_pkg::SC_NEG;
    endcase
  end

  assign sc_re = htg_pkg::scale_sat(pr_q, mode);
  assign sc_im = htg_pkg::scale_sat(prod_i, mode);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    walk_d      = walk_q;
    spins_d     = spins_q;
    cr_d        = cr_q;
    ci_d        = ci_q;
    pr_d        = pr_q;
    aligned_d   = aligned_q;
    out_d       = out_q;
    out_load    = 1'b0;
    in_ready_o  = 1'b0;
    rd_o.en     = 1'b0;
    rd_o.addr   = idx_q[htg_pkg::SLOT_W-1:0];
    mul_en_o    = 1'b0;
    mul_a_o     = cr_q;

    case (state_q)
      htg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept && in_data_i.opcode == htg_pkg::OP_APPLY) begin
          spins_d = in_data_i.spin_bits;
          cr_d    = in_data_i.coeff_real;
          ci_d    = in_data_i.coeff_imag;
          idx_d   = '0;
          walk_d  = (edges_in_use_i > WALK_MAX) ? WALK_MAX : edges_in_use_i;
          if (walk_d != '0) begin
            state_d = htg_pkg::ST_READ;
          end
        end
      end
      htg_pkg::ST_READ: begin
        rd_o.en = 1'b1;
        state_d = htg_pkg::ST_MUL_RE;
      end
      htg_pkg::ST_MUL_RE: begin
        mul_en_o  = 1'b1;
        mul_a_o   = cr_q;
        aligned_d = spin_a == spin_b;
        state_d   = htg_pkg::ST_MUL_IM;
      end
      htg_pkg::ST_MUL_IM: begin
        mul_en_o = 1'b1;
        mul_a_o  = ci_q;
        pr_d     = prod_i;
        state_d  = htg_pkg::ST_EMIT_DIAG;
      end
      htg_pkg::ST_EMIT_DIAG: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_d.term_real  = sc_re[htg_pkg::COEF_W-1:0];
          out_d.term_imag  = sc_im[htg_pkg::COEF_W-1:0];
          out_d.term_spins = spins_q;
          out_d.overflowed = sc_re[htg_pkg::COEF_W] || sc_im[htg_pkg::COEF_W];
          out_d.last_term  = aligned_q && last_edge;
          if (!aligned_q) begin
            state_d = htg_pkg::ST_EMIT_FLIP;
          end else if (last_edge) begin
            state_d = htg_pkg::ST_IDLE;
          end else begin
            idx_d   = idx_q + htg_pkg::CNT_W'(1);
            state_d = htg_pkg::ST_READ;
          end
        end
      end
      htg_pkg::ST_EMIT_FLIP: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_d.term_real  = sc_re[htg_pkg::COEF_W-1:0];
          out_d.term_imag  = sc_im[htg_pkg::COEF_W-1:0];
          out_d.term_spins = spins_q ^ flip_mask;
          out_d.overflowed = sc_re[htg_pkg::COEF_W] || sc_im[htg_pkg::COEF_W];
          out_d.last_term  = last_edge;
          if (last_edge) begin
            state_d = htg_pkg::ST_IDLE;
          end else begin
            idx_d   = idx_q + htg_pkg::CNT_W'(1);
            state_d = htg_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_d = htg_pkg::ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= htg_pkg::ST_IDLE;
      idx_q       <= '0;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    spins_q   <= spins_d;
    cr_q      <= cr_d;
    ci_q      <= ci_d;
    pr_q      <= pr_d;
    aligned_q <= aligned_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `HTG_ASSERT_NOW(a_flip_only_split, clk_i, rst_ni,
    state_q == htg_pkg::ST_EMIT_FLIP, !aligned_q, "flip term on aligned spins")
  `HTG_ASSERT_NOW(a_read_in_range, clk_i, rst_ni,
    state_q == htg_pkg::ST_READ, idx_q < walk_q && walk_q <= WALK_MAX,
    "edge index outside walk")
  `HTG_ASSERT_NEXT(a_last_ends_walk, clk_i, rst_ni,
    out_load && out_d.last_term, state_q == htg_pkg::ST_IDLE,
    "walk continues after last term")
  `HTG_ASSERT_NEXT(a_emit_fills_output, clk_i, rst_ni,
    out_load, out_valid_q, "emitted term not held in output register")

endmodule

### src/heisenberg_term_generator_unit.sv
// Top level of the Heisenberg term generator: APB register, edge table,
// shared multiplier and sequencer. Depends on htg_pkg, htg_edge_mem, htg_mult, htg_seq.
//
//  channel   direction  handshake                    word
//  in        input      in_valid_i / in_ready_o      htg_in_t (load or apply)
//  out       output     out_valid_o / out_ready_i    htg_out_t (one term)
//  cfg       input      APB psel/penable/pready      edges_in_use at address 0
//
// A load word with a slot inside the table writes that slot as it is taken. An apply
// word emits a diagonal term per edge, plus a flipped term for an edge with differing spins.
// Per edge: one table read, then two products through the single multiplier.
// Output stalls hold the walk in its emit step; the output register lets
// the next word be taken while the last term waits.
// Reset clears control state and edges_in_use; the edge table is not cleared.
module heisenberg_term_generator_unit #(
  parameter int unsigned SPIN_SITES   = 64,
  parameter int unsigned EDGE_ENTRIES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  htg_pkg::htg_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output htg_pkg::htg_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [htg_pkg::CNT_W-1:0]         edges_q;
  logic                              cfg_wr;
  logic                              tab_we;
  htg_pkg::htg_edge_t                tab_wdata;
  htg_pkg::htg_edge_t                tab_rdata;
  htg_pkg::htg_rd_req_t              tab_rd;
  logic                              mul_en;
  logic signed [htg_pkg::COEF_W-1:0] mul_a;
  logic signed [htg_pkg::PROD_W-1:0] prod;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
               && paddr[2] == htg_pkg::REG_EDGES_IN_USE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edges_q <= '0;
    end else if (cfg_wr) begin
      edges_q <= pwdata[htg_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    case (paddr[2])
      htg_pkg::REG_EDGES_IN_USE: prdata = {{(32-htg_pkg::CNT_W){1'b0}}, edges_q};
      default:                   prdata = '0;
    endcase
  end

  assign tab_we = in_valid_i && in_ready_o && in_data_i.opcode == htg_pkg::OP_LOAD
               && {1'b0, in_data_i.edge_slot} < (htg_pkg::SLOT_W+1)'(EDGE_ENTRIES);
  assign tab_wdata.site_a   = in_data_i.site_first;
  assign tab_wdata.site_b   = in_data_i.site_second;
  assign tab_wdata.coupling = in_data_i.edge_coupling;

  htg_edge_mem #(
    .DEPTH (EDGE_ENTRIES)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (in_data_i.edge_slot),
    .wdata_i (tab_wdata),
    .rd_i    (tab_rd),
    .rdata_o (tab_rdata)
  );

  htg_mult u_mult (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (tab_rdata.coupling),
    .prod_o (prod)
  );

  htg_seq #(
    .SPIN_SITES   (SPIN_SITES),
    .EDGE_ENTRIES (EDGE_ENTRIES)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .edges_in_use_i (edges_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o),
    .rd_o           (tab_rd),
    .rdata_i        (tab_rdata),
    .mul_en_o       (mul_en),
    .mul_a_o        (mul_a),
    .prod_i         (prod)
  );

endmodule
